>>> rtl/core/mtf_pkg.sv
// shared types and codes for the move-to-front search block
// request/response payload structs, opcode and status codes, controller commands
// no dependencies
package mtf_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [2:0] ST_APPENDED  = 3'd0;
   localparam logic [2:0] ST_FOUND     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_CLEARED   = 3'd4;

   localparam int POSITION_W = 6;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [POSITION_W-1:0] position;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and compare against the list
      logic update;    // apply the request to the list and form the response
   } ctrl_type;

endpackage

>>> rtl/core/mtf_datapath.sv
// datapath of the move-to-front search block: list cells, entry count,
// match register and response register; driven by mtf_controller commands
// depends on mtf_pkg
module mtf_datapath #(
   parameter int LIST_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mtf_pkg::ctrl_type cmd,
   input  mtf_pkg::req_type  req_data,
   output mtf_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int POS_W = (IDX_W > mtf_pkg::POSITION_W) ? IDX_W : mtf_pkg::POSITION_W;

   logic [31:0]           entries_ff [LIST_DEPTH];
   logic [CNT_W-1:0]      count_ff;
   logic [LIST_DEPTH-1:0] match_ff;
   logic [LIST_DEPTH-1:0] match_in;
   logic [1:0]            op_ff;
   logic [31:0]           key_ff;
   mtf_pkg::rsp_type      rsp_ff;
   mtf_pkg::rsp_type      rsp_in;

   logic [LIST_DEPTH-1:0] before_hit;
   logic [LIST_DEPTH-1:0] first_hit;
   logic                  any_hit;
   logic                  full;
   logic [IDX_W-1:0]      hit_idx;
   logic [POS_W-1:0]      hit_pos;

   // parallel compare against valid cells
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == req_data.key);
      end
   end

   // first match: no match in any lower cell
   always_comb begin
      logic [LIST_DEPTH-1:0] low_mask;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         low_mask      = (LIST_DEPTH'(1) << i) - LIST_DEPTH'(1);
         before_hit[i] = |(match_ff & low_mask);
      end
      first_hit = match_ff & ~before_hit;
      any_hit   = |match_ff;
   end

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
      hit_pos = POS_W'(hit_idx);
   end

   assign full = (count_ff == CNT_W'(LIST_DEPTH));

   always_comb begin
      rsp_in.status   = mtf_pkg::ST_NOT_FOUND;
      rsp_in.position = '0;
      case (op_ff)
         mtf_pkg::OP_APPEND: begin
            rsp_in.status = full ? mtf_pkg::ST_FULL : mtf_pkg::ST_APPENDED;
         end
         mtf_pkg::OP_SEARCH: begin
            if (any_hit) begin
               rsp_in.status   = mtf_pkg::ST_FOUND;
               rsp_in.position = hit_pos[mtf_pkg::POSITION_W-1:0];
            end
         end
         mtf_pkg::OP_CLEAR: begin
            rsp_in.status = mtf_pkg::ST_CLEARED;
         end
         default: begin
            rsp_in.status = mtf_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update) begin
         if (op_ff == mtf_pkg::OP_APPEND && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (op_ff == mtf_pkg::OP_CLEAR) begin
            count_ff <= '0;
         end
      end
   end

   // list cells: append writes the tail, a hit shifts the head down by one
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (op_ff == mtf_pkg::OP_APPEND && !full) begin
            entries_ff[count_ff[IDX_W-1:0]] <= key_ff;
         end else if (op_ff == mtf_pkg::OP_SEARCH && any_hit) begin
            entries_ff[0] <= key_ff;
            for (int i = 1; i < LIST_DEPTH; i++) begin
               if (!before_hit[i]) begin
                  entries_ff[i] <= entries_ff[i-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_data.opcode;
         key_ff   <= req_data.key;
         match_ff <= match_in;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/mtf_controller.sv
// controller of the move-to-front search block: two-state sequencer
// issues capture/update commands, drives busy and the response strobe
// depends on mtf_pkg
module mtf_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output mtf_pkg::ctrl_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               strobe_ff <= 1'b0;
               if (accept) begin
                  state_ff <= S_UPDATE;
                  busy_ff  <= 1'b1;
               end
            end
            S_UPDATE: begin
               state_ff  <= S_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff  <= S_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   assign cmd.capture = accept;
   assign cmd.update  = (state_ff == S_UPDATE);
   assign busy        = busy_ff;
   assign rsp_strobe  = strobe_ff;

endmodule

>>> rtl/core/move_to_front_search.sv
// top level of the move-to-front search block
// joins mtf_controller and mtf_datapath; depends on mtf_pkg
//
//   channel    ports                         direction  handshake
//   request    start, busy, req_data         in         start & !busy
//   response   rsp_strobe, rsp_data          out        rsp_strobe, one cycle
//
// for an accepted request, the accept edge compares the key against every list
// cell at once and the next edge shifts the list and loads the response.
// the response strobe is high in the cycle after that, while the next request
// may already be accepted; no request is taken while busy during the update.
// reset is synchronous and empties the list; cell contents are left as they are.
// the receiver cannot stall: every response is shown for exactly one cycle.
module move_to_front_search #(
   parameter int LIST_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mtf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mtf_pkg::rsp_type rsp_data
);

   // command bundle from sequencer to datapath
   mtf_pkg::ctrl_type cmd;

   // sequencer: idle / update
   mtf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // list cells, compare row and response register
   mtf_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // an accepted request always makes the block busy for the update cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // the update cycle is always followed by exactly one response strobe
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("update cycle not followed by a response");

   // no response without a request in flight in the cycle before
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a request");

   // a non-found response never carries a position
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != mtf_pkg::ST_FOUND) |-> (rsp_data.position == '0))
      else $error("position set on a response that is not a hit");

endmodule

>>> dv/move_to_front_search_tb.sv
// self-checking testbench for move_to_front_search: list model, random request driver, checker
// depends on mtf_pkg and the move_to_front_search rtl
module move_to_front_search_tb;

   localparam int LIST_DEPTH = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;      // ignored by the block, answers not found
   localparam int RANDOM_ITEMS = 1350;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      mtf_pkg::req_type req;
      bit               drain;    // hold this request until every response is back
   } pending_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   mtf_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   mtf_pkg::rsp_type rsp_data;

   pending_type        pending_reqs[$];
   mtf_pkg::rsp_type   expected_rsps[$];
   logic signed [31:0] stored_keys[$];       // keys appended since the last clear, any order

   // predicted list contents
   logic signed [31:0] list_keys[LIST_DEPTH];
   int                 list_len = 0;

   int total_items = 0;
   int accepted_n = 0;
   int done_n = 0;
   int mismatches = 0;
   int cycles = 0;

   move_to_front_search #(.LIST_DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one request to the predicted list and return the response it causes
   function automatic mtf_pkg::rsp_type apply_to_list(mtf_pkg::req_type r);
      mtf_pkg::rsp_type   rsp;
      int                 hit;
      logic signed [31:0] moved;
      rsp.status = mtf_pkg::ST_NOT_FOUND;
      rsp.position = '0;
      hit = -1;
      case (r.opcode)
         mtf_pkg::OP_APPEND: begin
            if (list_len < LIST_DEPTH) begin
               list_keys[list_len] = r.key;
               list_len++;
               rsp.status = mtf_pkg::ST_APPENDED;
            end else begin
               rsp.status = mtf_pkg::ST_FULL;
            end
         end
         mtf_pkg::OP_SEARCH: begin
            // first match from the front wins
            for (int i = 0; i < list_len; i++)
               if (hit < 0 && list_keys[i] == r.key) hit = i;
            if (hit >= 0) begin
               moved = list_keys[hit];
               for (int i = hit; i > 0; i--) list_keys[i] = list_keys[i-1];
               list_keys[0] = moved;
               rsp.status = mtf_pkg::ST_FOUND;
               rsp.position = mtf_pkg::POSITION_W'(hit);
            end
         end
         mtf_pkg::OP_CLEAR: begin
            list_len = 0;
            rsp.status = mtf_pkg::ST_CLEARED;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic add_req(logic [1:0] op, logic signed [31:0] key, bit drain = 1'b0);
      pending_type p;
      p.req.opcode = op;
      p.req.key = key;
      p.drain = drain;
      pending_reqs.push_back(p);
      total_items++;
      if (op == mtf_pkg::OP_APPEND && stored_keys.size() < LIST_DEPTH)
         stored_keys.push_back(key);
      if (op == mtf_pkg::OP_CLEAR) stored_keys.delete();
   endtask

   function automatic logic signed [31:0] fresh_key();
      case ($urandom_range(0, 3))
         0: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] stored_or_fresh(int odds_stored);
      if (stored_keys.size() > 0 && $urandom_range(0, 99) < odds_stored)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      return fresh_key();
   endfunction

   // stimulus, then end of run
   initial begin
      int fill, steps, appended, pick, episode;

      // directed: empty search, extremes, duplicates, front hit, ignored opcode, clear
      add_req(mtf_pkg::OP_SEARCH, 32'sd0);
      add_req(mtf_pkg::OP_APPEND, 32'sh7fffffff);
      add_req(mtf_pkg::OP_APPEND, 32'sh80000000);
      add_req(mtf_pkg::OP_APPEND, 32'sd0);
      add_req(mtf_pkg::OP_APPEND, -32'sd1);
      add_req(mtf_pkg::OP_APPEND, 32'sd5);
      add_req(mtf_pkg::OP_APPEND, 32'sd5);
      add_req(mtf_pkg::OP_SEARCH, 32'sd5);              // first of two equal keys
      add_req(mtf_pkg::OP_SEARCH, 32'sd5);              // already at the front
      add_req(mtf_pkg::OP_SEARCH, 32'sh80000000);
      add_req(mtf_pkg::OP_SEARCH, 32'sh7fffffff);
      add_req(mtf_pkg::OP_SEARCH, -32'sd1);
      add_req(mtf_pkg::OP_SEARCH, 32'sd123);            // miss
      add_req(OP_UNUSED, -32'sd1);
      add_req(OP_UNUSED, 32'sh55555555);
      add_req(mtf_pkg::OP_APPEND, 32'sd7);              // append after reordering lands at the tail
      add_req(mtf_pkg::OP_SEARCH, 32'sd7);
      add_req(mtf_pkg::OP_SEARCH, 32'sd0);
      add_req(mtf_pkg::OP_CLEAR, 32'sh2aaaaaaa);
      add_req(mtf_pkg::OP_SEARCH, 32'sd5);              // gone after clear
      add_req(mtf_pkg::OP_APPEND, 32'sd1);
      add_req(mtf_pkg::OP_SEARCH, 32'sd1);

      // random episodes: clear, fill (a third of them up to full or past it), mostly hitting searches
      episode = 0;
      while (total_items < RANDOM_ITEMS + 22) begin
         add_req(mtf_pkg::OP_CLEAR, $signed($urandom), episode % 4 == 0);
         fill = ($urandom_range(0, 2) == 0) ? LIST_DEPTH + $urandom_range(0, 4)
                                            : $urandom_range(1, 30);
         steps = 2 * fill + $urandom_range(5, 30);
         appended = 0;
         repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               add_req(OP_UNUSED, $signed($urandom));
            end else if (pick < 58 && appended < fill) begin
               add_req(mtf_pkg::OP_APPEND, stored_or_fresh(20));
               appended++;
            end else begin
               add_req(mtf_pkg::OP_SEARCH, stored_or_fresh(75));
            end
         end
         episode++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (!(accepted_n == total_items && done_n == total_items)) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("move_to_front_search test passed");
      end else begin
         $display("move_to_front_search test failed");
      end
      $finish;
   end

   // driver: offers the next pending request, with random gaps and a drain pause
   always @(posedge clock) begin
      bit          took;
      bit          steady;
      int          owed;
      pending_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            expected_rsps.push_back(apply_to_list(req_data));
            accepted_n <= accepted_n + 1;
         end
         if (took || !start) begin
            // responses still owed once this edge's strobe is counted
            owed = accepted_n + int'(took) - done_n - int'(rsp_strobe);
            steady = accepted_n >= 500 && accepted_n < 750;
            if (pending_reqs.size() == 0) begin
               start <= 1'b0;
            end else if (pending_reqs[0].drain && owed > 0) begin
               start <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 14) begin
               start <= 1'b0;
            end else begin
               nxt = pending_reqs.pop_front();
               start <= 1'b1;
               req_data <= nxt.req;
            end
         end
      end
   end

   // monitor: every strobed response against the oldest prediction
   always @(posedge clock) begin
      mtf_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         done_n <= done_n + 1;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: status %0d position %0d",
                        rsp_data.status, rsp_data.position);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.position !== want.position) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response %0d: expected status %0d position %0d, ",
                            "got status %0d position %0d"},
                           done_n, want.status, want.position,
                           rsp_data.status, rsp_data.position);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("move_to_front_search test failed");
         $finish;
      end
   end

endmodule

>>> sim.f
rtl/core/mtf_pkg.sv
rtl/core/mtf_datapath.sv
rtl/core/mtf_controller.sv
rtl/core/move_to_front_search.sv
dv/move_to_front_search_tb.sv
